// File: rtl/aes_block_encrypt_decrypt_unit_assert.svh
// Assertion macros used by the cipher controller.
`ifndef AES_BLOCK_ENCRYPT_DECRYPT_UNIT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_DECRYPT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define AES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define AES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/aes_pkg.sv
// Shared types, constants and GF(2^8) helpers for the AES cipher.
package aes_pkg;

  localparam int unsigned RND_W  = 4;  // round number, up to 14
  localparam int unsigned WIDX_W = 6;  // key schedule word index, up to 59
  localparam int unsigned CIDX_W = 3;  // configuration register index

  localparam logic [CIDX_W-1:0] CFG_KEY0 = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_KEY1 = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_KEY2 = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_KEY3 = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_KSZ  = 3'd4;

  localparam logic [1:0] KSZ_128 = 2'd0;
  localparam logic [1:0] KSZ_192 = 2'd1;
  localparam logic [1:0] KSZ_256 = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic              load_in;   // latch the accepted request
    logic              key_init;  // restart the schedule generator
    logic              key_step;  // produce one schedule word
    logic [WIDX_W-1:0] key_idx;   // index of that word
    logic [RND_W-1:0]  nr;        // active round count
    logic              rd_en;     // read one round key row
    logic [RND_W-1:0]  rd_addr;
    logic              add0;      // initial key addition
    logic              round;     // one cipher round
    logic              last;      // final round, no column mix
    logic              out_load;  // move the result to the output register
  } aes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] key_size;
    logic       cfg_wr;  // a listed register was written
  } aes_status_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  // Forward S-box, worked out at elaboration.
  function automatic logic [255:0][7:0] build_sbox();
    logic [255:0][7:0] t;
    logic [7:0] base;
    logic [7:0] inv;
    for (int x = 0; x < 256; x++) begin
      base = x[7:0];
      inv  = 8'h01;
      for (int k = 0; k < 7; k++) begin
        base = gf_mul(base, base);
        inv  = gf_mul(inv, base);
      end
      if (x == 0) inv = 8'h00;
      t[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
    end
    return t;
  endfunction

  localparam logic [255:0][7:0] SBOX = build_sbox();

  function automatic logic [255:0][7:0] build_inv_sbox();
    logic [255:0][7:0] t;
    for (int x = 0; x < 256; x++) t[SBOX[x]] = x[7:0];
    return t;
  endfunction

  localparam logic [255:0][7:0] INV_SBOX = build_inv_sbox();

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
            xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int i = 0; i < 4; i++) begin
      a[i]  = w[31-8*i -: 8];
      m2[i] = xt(a[i]);
      m4[i] = xt(m2[i]);
      m8[i] = xt(m4[i]);
      m9[i] = m8[i] ^ a[i];
      mb[i] = m8[i] ^ m2[i] ^ a[i];
      md[i] = m8[i] ^ m4[i] ^ a[i];
      me[i] = m8[i] ^ m4[i] ^ m2[i];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // SubBytes then ShiftRows; byte 0 is the top byte.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  // InvShiftRows then InvSubBytes.
  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[s[127-8*(4*c+r) -: 8]];
      end
    end
    return t;
  endfunction

endpackage

// File: rtl/aes_block_encrypt_decrypt_unit.sv
// Top level of the AES-128/192/256 single-block cipher.
// Usage:
//   Write the key words and key size on the cfg port while the block is idle.
//   Any listed register write drops the stored round key schedule.
//   A request on the input channel (op, 128-bit block) is taken when
//   in_valid_i is high and in_stall_o is low; in_stall_o is low only when idle.
//   One result per request leaves on the output channel when out_valid_o is
//   high and out_stall_i is low. The output register holds the result while
//   the receiver stalls, and the next request may be taken meanwhile.
// Steps after accept: read round key row 0, initial key addition, then Nr
//   rounds (Nr = 10, 12 or 14), one AES round per cycle, the round key read
//   from a 128-bit-wide row memory one read ahead of its round.
// The first request after reset or a register write first expands the
//   schedule, one 32-bit word per cycle: 4*(Nr+1) words (44 to 60).
// A new request is taken only once the last one is loaded into the output
//   register; a stalled result delays the next one only once it is finished.
// Reset clears the key registers, the key size, the schedule valid flag and
//   both channels; the round key memories are not cleared.
module aes_block_encrypt_decrypt_unit #(
  parameter int unsigned ROUND_KEY_WORDS = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [63:0] data_in_high_i,
  input  logic [63:0] data_in_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] data_out_high_o,
  output logic [63:0] data_out_low_o
);
  import aes_pkg::*;

  aes_cmd_t    cmd;
  aes_status_t status;

  // Sequence expansion and rounds
  aes_ctrl #(
    .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Hold keys and compute
  aes_dp #(
    .ROUND_KEY_WORDS(ROUND_KEY_WORDS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (op_i),
    .data_in_high_i  (data_in_high_i),
    .data_in_low_i   (data_in_low_i),
    .data_out_high_o (data_out_high_o),
    .data_out_low_o  (data_out_low_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

// File: rtl/aes_dp.sv
// Datapath: key registers, schedule generator, round key memories, round unit.
module aes_dp #(
  parameter int unsigned ROUND_KEY_WORDS = 60
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [63:0]                cfg_wdata_i,
  input  logic                       op_i,
  input  logic [63:0]                data_in_high_i,
  input  logic [63:0]                data_in_low_i,
  output logic [63:0]                data_out_high_o,
  output logic [63:0]                data_out_low_o,
  input  aes_pkg::aes_cmd_t          cmd_i,
  output aes_pkg::aes_status_t       status_o
);
  import aes_pkg::*;

  localparam int unsigned ROWS = ROUND_KEY_WORDS / 4;
  localparam int unsigned RW   = $clog2(ROWS);

  logic [63:0]  key_q [4];
  logic [1:0]   ksz_q;
  logic [31:0]  win_q [8];
  logic [3:0]   kmod_q;
  logic [7:0]   rcon_q;
  logic [127:0] enc_mem [ROWS];
  logic [127:0] dec_mem [ROWS];
  logic [127:0] rk_q;
  logic [127:0] st_q;
  logic [127:0] out_q;
  logic         op_q;

  logic [3:0]   nk;
  logic         loading;
  logic [63:0]  kreg;
  logic [31:0]  kw;
  logic [31:0]  t;
  logic [31:0]  new_w;
  logic [127:0] row;
  logic [RND_W-1:0] row_idx;
  logic [RND_W-1:0] dec_idx;
  logic [127:0] dec_row;
  logic [127:0] ss;
  logic [127:0] mixed;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      ksz_q <= KSZ_128;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY0: key_q[0] <= cfg_wdata_i;
        CFG_KEY1: key_q[1] <= cfg_wdata_i;
        CFG_KEY2: key_q[2] <= cfg_wdata_i;
        CFG_KEY3: key_q[3] <= cfg_wdata_i;
        CFG_KSZ:  ksz_q    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign status_o.key_size = ksz_q;
  assign status_o.cfg_wr   = cfg_we_i && (cfg_idx_i <= CFG_KSZ);

  // Next schedule word
  assign nk      = cmd_i.nr - 4'd6;
  assign loading = {2'b00, cmd_i.key_idx} < {4'b0000, nk};
  assign kreg    = key_q[cmd_i.key_idx[2:1]];
  assign kw      = cmd_i.key_idx[0] ? kreg[31:0] : kreg[63:32];

  always_comb begin
    t = win_q[0];
    if (kmod_q == 4'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon_q, 24'h000000};
    end else if (nk == 4'd8 && kmod_q == 4'd4) begin
      t = sub_word(t);
    end
    new_w = loading ? kw : (win_q[nk[2:0] - 3'd1] ^ t);
  end

  // Advance the word window and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmod_q <= '0;
      rcon_q <= 8'h01;
    end else if (cmd_i.key_init) begin
      kmod_q <= '0;
      rcon_q <= 8'h01;
    end else if (cmd_i.key_step) begin
      kmod_q <= (kmod_q == nk - 4'd1) ? 4'd0 : kmod_q + 4'd1;
      if (!loading && kmod_q == 4'd0) rcon_q <= xt(rcon_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_step) begin
      win_q[0] <= new_w;
      for (int i = 1; i < 8; i++) win_q[i] <= win_q[i-1];
    end
  end

  // Store a full row in forward and equivalent-inverse form
  assign row     = {win_q[2], win_q[1], win_q[0], new_w};
  assign row_idx = cmd_i.key_idx[WIDX_W-1:2];
  assign dec_idx = cmd_i.nr - row_idx;
  assign dec_row = (row_idx == '0 || row_idx == cmd_i.nr) ? row :
                   {inv_mix_col(row[127:96]), inv_mix_col(row[95:64]),
                    inv_mix_col(row[63:32]), inv_mix_col(row[31:0])};

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_step && cmd_i.key_idx[1:0] == 2'b11) begin
      enc_mem[row_idx[RW-1:0]] <= row;
      dec_mem[dec_idx[RW-1:0]] <= dec_row;
    end
  end

  // Read one round key row
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rk_q <= op_q ? dec_mem[cmd_i.rd_addr[RW-1:0]] : enc_mem[cmd_i.rd_addr[RW-1:0]];
    end
  end

  // Round unit
  always_comb begin
    if (op_q) begin
      ss    = inv_sub_shift(st_q);
      mixed = {inv_mix_col(ss[127:96]), inv_mix_col(ss[95:64]),
               inv_mix_col(ss[63:32]), inv_mix_col(ss[31:0])};
    end else begin
      ss    = sub_shift(st_q);
      mixed = {mix_col(ss[127:96]), mix_col(ss[95:64]),
               mix_col(ss[63:32]), mix_col(ss[31:0])};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      st_q <= {data_in_high_i, data_in_low_i};
      op_q <= op_i;
    end else if (cmd_i.add0) begin
      st_q <= st_q ^ rk_q;
    end else if (cmd_i.round) begin
      st_q <= (cmd_i.last ? ss : mixed) ^ rk_q;
    end
    if (cmd_i.out_load) out_q <= st_q;
  end

  assign data_out_high_o = out_q[127:64];
  assign data_out_low_o  = out_q[63:0];

endmodule

// File: rtl/aes_ctrl.sv
// Controller: schedule expansion, round sequencing and handshakes.
module aes_ctrl #(
  parameter int unsigned ROUND_KEY_WORDS = 60
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output aes_pkg::aes_cmd_t    cmd_o,
  input  aes_pkg::aes_status_t status_i
);
  import aes_pkg::*;

  localparam logic [RND_W-1:0] MAX_NR = (ROUND_KEY_WORDS >= 60) ? 4'd14 :
                                        (ROUND_KEY_WORDS >= 52) ? 4'd12 : 4'd10;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXPAND = 6'b000010,
    ST_KEY0   = 6'b000100,
    ST_ADD0   = 6'b001000,
    ST_ROUND  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic              ready_q, ready_d;
  logic [RND_W-1:0]  nr_q, nr_d;
  logic [RND_W-1:0]  rnd_q, rnd_d;
  logic [WIDX_W-1:0] idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;
  logic [RND_W-1:0]  req_nr;
  logic              last_word;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign req_nr   = (status_i.key_size == KSZ_128) ? 4'd10 :
                    (status_i.key_size == KSZ_192 && MAX_NR >= 4'd12) ? 4'd12 : MAX_NR;
  assign last_word = idx_q == {nr_q, 2'b11};

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    ready_d     = ready_q;
    nr_d        = nr_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o          = '0;
    cmd_o.nr       = nr_q;
    cmd_o.key_idx  = idx_q;
    cmd_o.last     = rnd_q == nr_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          if (ready_q) begin
            state_d = ST_KEY0;
          end else begin
            cmd_o.key_init = 1'b1;
            nr_d    = req_nr;
            idx_d   = '0;
            state_d = ST_EXPAND;
          end
        end
      end
      ST_EXPAND: begin
        cmd_o.key_step = 1'b1;
        idx_d = idx_q + 1'b1;
        if (last_word) begin
          ready_d = 1'b1;
          state_d = ST_KEY0;
        end
      end
      ST_KEY0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
        state_d = ST_ADD0;
      end
      ST_ADD0: begin
        cmd_o.add0    = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = 4'd1;
        rnd_d   = 4'd1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round   = 1'b1;
        cmd_o.rd_en   = rnd_q != nr_q;
        cmd_o.rd_addr = rnd_q + 4'd1;
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == nr_q) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // drop the schedule on any listed register write
    if (status_i.cfg_wr) ready_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ready_q     <= 1'b0;
      nr_q        <= 4'd10;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      nr_q        <= nr_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

`include "aes_block_encrypt_decrypt_unit_assert.svh"

  `AES_ASSERT_IMP(a_word_in_range, cmd_o.key_step, idx_q <= {nr_q, 2'b11}, "schedule word past end")
  `AES_ASSERT_IMP(a_round_in_range, state_q == ST_ROUND, rnd_q >= 4'd1 && rnd_q <= nr_q, "round count out of range")
  `AES_ASSERT_IMP(a_no_overwrite, cmd_o.out_load, !(out_valid_q && out_stall_i), "result overwritten")
  `AES_ASSERT_NXT(a_expand_ready, state_q == ST_EXPAND && last_word && !status_i.cfg_wr, ready_q, "schedule not marked ready")

endmodule

// File: dv/aes_block_encrypt_decrypt_unit_test.sv
// Self-checking testbench for the single-block AES encrypt/decrypt unit.
module aes_block_encrypt_decrypt_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_PER_PHASE = 110;
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef struct packed {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op_r = 1'b0;
  logic [63:0] hi_r = '0;
  logic [63:0] lo_r = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hi;
  logic [63:0] out_lo;

  // model copy of the registers and the expanded schedule
  logic [63:0] key_regs [4];
  logic [1:0]  key_len;
  logic [31:0] rk_enc [60];
  logic [31:0] rk_dec [60];
  int unsigned rounds;
  logic [7:0]  fwd_box [256];
  logic [7:0]  inv_box [256];

  block_req_t   pending [$];
  logic [127:0] result_due [$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  burst_left = 4;
  int unsigned  gap_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_window = 0;

  aes_block_encrypt_decrypt_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op_r),
    .data_in_high_i (hi_r),
    .data_in_low_i  (lo_r),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .data_out_high_o(out_hi),
    .data_out_low_o (out_lo)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Build the S-boxes from the field inverse and the affine map.
  function automatic void build_boxes();
    logic [7:0] v;
    logic [7:0] e;
    for (int x = 0; x < 256; x++) begin
      v = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) v = y[7:0];
      e = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]} ^ 8'h63;
      fwd_box[x] = e;
      inv_box[e] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
  endfunction

  function automatic logic [31:0] unmix_word(logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {gmul(a0, 14) ^ gmul(a1, 11) ^ gmul(a2, 13) ^ gmul(a3, 9),
            gmul(a0, 9) ^ gmul(a1, 14) ^ gmul(a2, 11) ^ gmul(a3, 13),
            gmul(a0, 13) ^ gmul(a1, 9) ^ gmul(a2, 14) ^ gmul(a3, 11),
            gmul(a0, 11) ^ gmul(a1, 13) ^ gmul(a2, 9) ^ gmul(a3, 14)};
  endfunction

  // Expand forward and equivalent-inverse round keys; size three acts as 256.
  function automatic void expand_keys();
    int unsigned nk, total;
    logic [31:0] t;
    logic [7:0]  rc;
    rounds = (key_len > KSZ_256) ? 14 : 10 + 2 * key_len;
    nk = rounds - 6;
    total = 4 * (rounds + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rk_enc[i] = (i % 2) ? key_regs[i / 2][31:0] : key_regs[i / 2][63:32];
    for (int i = nk; i < total; i++) begin
      t = rk_enc[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      rk_enc[i] = rk_enc[i - nk] ^ t;
    end
    for (int r = 0; r <= rounds; r++)
      for (int c = 0; c < 4; c++)
        rk_dec[4 * r + c] = (r == 0 || r == rounds) ? rk_enc[4 * (rounds - r) + c]
                                                   : unmix_word(rk_enc[4 * (rounds - r) + c]);
  endfunction

  // Work out the cipher result of one block under the current key.
  function automatic logic [127:0] cipher_block(logic op, logic [127:0] blk);
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [31:0] k;
    logic [31:0] col;
    logic [7:0]  a0, a1, a2, a3;
    logic [127:0] res;
    expand_keys();
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int r = 0; r <= rounds; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++)
          for (int b = 0; b < 4; b++) begin
            if (op == OP_DEC) t[4 * ((c + b) % 4) + b] = inv_box[s[4 * c + b]];
            else t[4 * c + b] = fwd_box[s[4 * ((c + b) % 4) + b]];
          end
        s = t;
        if (r < rounds)
          for (int c = 0; c < 4; c++) begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            if (op == OP_DEC) begin
              col = unmix_word({a0, a1, a2, a3});
            end else begin
              col = {gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3,
                     a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3,
                     a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3),
                     gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2)};
            end
            {s[4 * c], s[4 * c + 1], s[4 * c + 2], s[4 * c + 3]} = col;
          end
      end
      for (int c = 0; c < 4; c++) begin
        k = (op == OP_DEC) ? rk_dec[4 * r + c] : rk_enc[4 * r + c];
        for (int b = 0; b < 4; b++) s[4 * c + b] ^= k[31 - 8 * b -: 8];
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  // Driver: accept, predict, then hold or present the next request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall)
        result_due.push_back(cipher_block(op_r, {hi_r, lo_r}));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          block_req_t req;
          req = pending.pop_front();
          in_valid <= 1'b1;
          op_r <= req.op;
          hi_r <= req.hi;
          lo_r <= req.lo;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, then drive out_stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (result_due.size() == 0) begin
        $error("result with no request outstanding: %h %h", out_hi, out_lo);
        errors++;
      end else begin
        logic [127:0] want;
        want = result_due.pop_front();
        if (out_hi !== want[127:64]) begin
          $error("data_out_high expected %h actual %h", want[127:64], out_hi);
          errors++;
        end
        if (out_lo !== want[63:0]) begin
          $error("data_out_low expected %h actual %h", want[63:0], out_lo);
          errors++;
        end
      end
    end
    if (stall_window == 0) begin
      stall_window = $urandom_range(20, 200);
      stall_mode = $urandom_range(0, 2);
    end
    stall_window--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    if (idx <= CFG_KEY3) key_regs[idx[1:0]] = val;
    else if (idx == CFG_KSZ) key_len = val[1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Drain all traffic, then let the block settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending.size() > 0 || in_valid || result_due.size() > 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic push_block(logic op, logic [63:0] hi, logic [63:0] lo);
    pending.push_back('{op: op, hi: hi, lo: lo});
  endtask

  task automatic push_random(int unsigned n);
    for (int i = 0; i < n; i++)
      push_block(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] k3, logic [1:0] size);
    cfg_write(CFG_KEY0, k0);
    cfg_write(CFG_KEY1, k1);
    cfg_write(CFG_KEY2, k2);
    cfg_write(CFG_KEY3, k3);
    cfg_write(CFG_KSZ, {62'h0, size});
  endtask

  initial begin
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    key_len = KSZ_128;
    build_boxes();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key: edge blocks in both directions, then random blocks.
    for (int o = 0; o < 2; o++) begin
      push_block(o[0], 64'h0, 64'h0);
      push_block(o[0], '1, '1);
      push_block(o[0], 64'h0011223344556677, 64'h8899aabbccddeeff);
      push_block(o[0], 64'h8000000000000000, 64'h0000000000000001);
      push_block(o[0], 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    end
    push_random(RANDOM_PER_PHASE);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, KSZ_128);
        1: load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                    64'h1011121314151617, '0, KSZ_192);
        2: load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                    64'h1011121314151617, 64'h18191a1b1c1d1e1f, KSZ_256);
        3: load_key('1, '1, '1, '1, 2'd3);
        4: load_key('0, '0, '0, '0, KSZ_192);
        default: load_key({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom},
                          2'($urandom_range(0, 3)));
      endcase
      // Unlisted indexes must leave the key alone.
      if (phase % 3 == 1) cfg_write(3'($urandom_range(5, 7)), {$urandom, $urandom});
      if (phase < 3) begin
        push_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_block(OP_DEC, 64'h0011223344556677, 64'h8899aabbccddeeff);
      end
      push_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
